@@ rtl/refcount_slot_allocator_macros.svh @@
// assertion macros for the slot allocator checker
// clock clk_i and active-low reset rst_ni must be visible where they are used
`ifndef REFCOUNT_SLOT_ALLOCATOR_MACROS_SVH
`define REFCOUNT_SLOT_ALLOCATOR_MACROS_SVH

// property checked at every rising clock edge, off while in reset
`define RSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked at every rising clock edge, also in reset
`define RSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/rsa_pkg.sv @@
// shared types and constants of the reference counted slot allocator
// no dependencies
`default_nettype none

package rsa_pkg;

  localparam int ID_W = 9;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_INC   = 2'd1,
    CMD_DEC   = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2,
    ST_SAT  = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // per pool enables from the controller, index 0 variables, 1 paths
  typedef struct packed {
    logic [1:0] load;
    logic [1:0] exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [ID_W-1:0] rid;
    logic            unbound;
    logic            freed;
    status_e         status;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/rsa_ram.sv @@
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module rsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/rsa_pool.sv @@
// datapath of one slot pool: count ram, free stack ram, stack top, high-water mark
// depends on rsa_pkg and rsa_ram
`default_nettype none

module rsa_pool #(
  parameter int SLOTS      = 256,
  parameter int BASE       = 0,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       load_i,
  input  wire logic                       exec_i,
  input  wire rsa_pkg::cmd_e              command_i,
  input  wire logic [rsa_pkg::ID_W-1:0]   slot_id_i,
  output rsa_pkg::res_t                   res_o
);

  import rsa_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int TW = $clog2(SLOTS + 1);
  localparam int XW = (TW > ID_W + 1) ? TW : ID_W + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [TW-1:0]   top_q, top_d, high_q, high_d;
  cmd_e            cmd_q;
  logic [ID_W-1:0] sid_q;
  logic [IW-1:0]   idx_q;
  logic            hit_q, nil_q, pop_q, fresh_q;

  logic [XW-1:0]         off;
  logic [IW-1:0]         stk_raddr, a_idx;
  logic [COUNT_BITS-1:0] cnt_rd, cnt_wdata;
  logic [IW-1:0]         stk_rd, cnt_waddr, stk_waddr, stk_wdata;
  logic                  cnt_we, stk_we;

  // path id zero wraps here but is caught by nil_q
  assign off       = XW'(slot_id_i) - XW'(BASE);
  assign stk_raddr = IW'(top_q - TW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= '0;
      high_q <= '0;
    end else begin
      top_q  <= top_d;
      high_q <= high_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cmd_q   <= command_i;
      sid_q   <= slot_id_i;
      idx_q   <= off[IW-1:0];
      hit_q   <= off < XW'(high_q);
      nil_q   <= (BASE != 0) && (slot_id_i == '0);
      pop_q   <= top_q != '0;
      fresh_q <= high_q < TW'(SLOTS);
    end
  end

  // counts at or above the high-water mark are never used, so no clearing is needed
  rsa_ram #(.WIDTH(COUNT_BITS), .DEPTH(SLOTS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (load_i),
    .raddr_i (off[IW-1:0]),
    .rdata_o (cnt_rd)
  );

  rsa_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (load_i),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rd)
  );

  assign a_idx = pop_q ? stk_rd : high_q[IW-1:0];

  always_comb begin
    res_o.rid     = sid_q;
    res_o.unbound = 1'b0;
    res_o.freed   = 1'b0;
    res_o.status  = ST_OK;
    cnt_we        = 1'b0;
    cnt_waddr     = idx_q;
    cnt_wdata     = cnt_rd;
    stk_we        = 1'b0;
    stk_waddr     = top_q[IW-1:0];
    stk_wdata     = idx_q;
    top_d         = top_q;
    high_d        = high_q;
    if (exec_i) begin
      if (cmd_q == CMD_ALLOC) begin
        if (pop_q || fresh_q) begin
          cnt_we    = 1'b1;
          cnt_waddr = a_idx;
          cnt_wdata = COUNT_BITS'(1);
          res_o.rid = ID_W'(XW'(a_idx) + XW'(BASE));
          if (pop_q) begin
            top_d = top_q - TW'(1);
          end else begin
            high_d = high_q + TW'(1);
          end
        end else begin
          res_o.rid    = '0;
          res_o.status = ST_FULL;
        end
      end else if (nil_q) begin
        res_o.status = ST_OK;
      end else if (!hit_q || cnt_rd == '0) begin
        res_o.status = ST_BAD;
      end else begin
        res_o.unbound = cnt_rd == COUNT_BITS'(1);
        unique case (cmd_q)
          CMD_INC: begin
            if (cnt_rd == CNT_MAX) begin
              res_o.status = ST_SAT;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_rd + COUNT_BITS'(1);
            end
          end
          CMD_DEC: begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_rd - COUNT_BITS'(1);
            if (cnt_rd == COUNT_BITS'(1)) begin
              res_o.freed = 1'b1;
              if (top_q < TW'(SLOTS)) begin
                stk_we = 1'b1;
                top_d  = top_q + TW'(1);
              end
            end
          end
          CMD_ALLOC, CMD_QUERY: begin
            cnt_we = 1'b0;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/rsa_ctrl.sv @@
// controller state machine: accepts a request, then runs the execute state
// depends on rsa_pkg
`default_nettype none

module rsa_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  wire logic           pool_i,
  output logic                busy,
  output rsa_pkg::ctrl_cmd_t  cmd_o
);

  import rsa_pkg::*;

  state_e state_q, state_d;
  logic   sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && start) begin
        sel_q <= pool_i;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    busy         = 1'b0;
    cmd_o.load   = 2'b00;
    cmd_o.exec   = 2'b00;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load[0] = start && !pool_i;
        cmd_o.load[1] = start && pool_i;
      end
      S_EXEC: begin
        busy          = 1'b1;
        cmd_o.exec[0] = !sel_q;
        cmd_o.exec[1] = sel_q;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/refcount_slot_allocator.sv @@
// done_o and the result are registered from the execute state, after the accepting edge
// a new request is accepted only when not busy; busy is high for the single execute cycle
// the execute state uses the count and free stack ram reads and writes them back
// reset clears stack tops and high-water marks at once, no ram clearing pass
// results show for one cycle only; the receiver cannot stall them
`default_nettype none

module refcount_slot_allocator #(
  parameter int VAR_SLOTS  = 256,
  parameter int PATH_SLOTS = 256,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire rsa_pkg::cmd_e            command_i,
  input  wire logic                     pool_i,
  input  wire logic [rsa_pkg::ID_W-1:0] slot_id_i,
  output logic                          done_o,
  output logic [rsa_pkg::ID_W-1:0]      result_id_o,
  output logic                          unbound_o,
  output logic                          freed_o,
  output rsa_pkg::status_e              status_o
);

  import rsa_pkg::*;

  ctrl_cmd_t cmd;
  res_t      var_res, path_res, res_q;
  logic      done_q;

  rsa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .pool_i (pool_i),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  rsa_pool #(.SLOTS(VAR_SLOTS), .BASE(0), .COUNT_BITS(COUNT_BITS)) u_var_pool (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (cmd.load[0]),
    .exec_i    (cmd.exec[0]),
    .command_i (command_i),
    .slot_id_i (slot_id_i),
    .res_o     (var_res)
  );

  rsa_pool #(.SLOTS(PATH_SLOTS), .BASE(1), .COUNT_BITS(COUNT_BITS)) u_path_pool (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (cmd.load[1]),
    .exec_i    (cmd.exec[1]),
    .command_i (command_i),
    .slot_id_i (slot_id_i),
    .res_o     (path_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd.exec != 2'b00;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.exec != 2'b00) begin
      res_q <= cmd.exec[1] ? path_res : var_res;
    end
  end

  assign done_o      = done_q;
  assign result_id_o = res_q.rid;
  assign unbound_o   = res_q.unbound;
  assign freed_o     = res_q.freed;
  assign status_o    = res_q.status;

endmodule

`default_nettype wire

@@ rtl/rsa_checker.sv @@
// port level checks of the slot allocator, bound to the top level
// depends on rsa_pkg and refcount_slot_allocator_macros.svh
`default_nettype none

`include "refcount_slot_allocator_macros.svh"

module rsa_checker (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic                     done_o,
  input wire logic [rsa_pkg::ID_W-1:0] result_id_o,
  input wire logic                     unbound_o,
  input wire logic                     freed_o,
  input wire rsa_pkg::status_e         status_o
);

  import rsa_pkg::*;

  // an accepted request is executed while busy is high, then its result shows
  `RSA_ASSERT(a_accept_result, start && !busy |=> busy ##1 done_o, "request result missing")
  `RSA_ASSERT(a_single_busy, busy |=> !busy, "busy longer than one cycle")
  `RSA_ASSERT(a_done_idle, done_o |-> !busy, "result shown while busy")
  // a freed slot had count one and the decrement succeeded
  `RSA_ASSERT(a_freed_ok, done_o && freed_o |-> unbound_o && status_o == ST_OK, "bad freed result")
  `RSA_ASSERT_ALWAYS(a_full_zero, done_o && status_o == ST_FULL |-> result_id_o == '0,
                     "pool full with nonzero id")

endmodule

bind refcount_slot_allocator rsa_checker u_rsa_checker (.*);

`default_nettype wire

@@ tb/slot_allocator_checker.sv @@
// checker for the slot allocator: predicts each request's answer and compares it
// with the result strobe. depends on rsa_pkg
module slot_allocator_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  rsa_pkg::cmd_e            command_i,
  input  logic                     pool_i,
  input  logic [rsa_pkg::ID_W-1:0] slot_id_i,
  input  logic                     done_i,
  input  logic [rsa_pkg::ID_W-1:0] result_id_i,
  input  logic                     unbound_i,
  input  logic                     freed_i,
  input  rsa_pkg::status_e         status_i,
  output int                       errors_o,
  output int                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import rsa_pkg::*;

  localparam int POOL_SLOTS = 256;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  logic [15:0]     slot_count [2][POOL_SLOTS];
  logic [ID_W-1:0] free_ids [2][POOL_SLOTS];
  int              free_depth [2];
  int              fresh_mark [2];
  res_t            expected_answers [$];
  int              error_count;

  assign errors_o  = error_count;
  assign pending_o = expected_answers.size();

  // answer of one request, updating the mirrored pool state
  function automatic res_t apply_request(cmd_e cmd, logic sel, logic [ID_W-1:0] sid);
    res_t r;
    int   base;
    int   idx;
    r.rid     = sid;
    r.unbound = 1'b0;
    r.freed   = 1'b0;
    r.status  = ST_OK;
    base      = sel ? 1 : 0;
    if (cmd == CMD_ALLOC) begin
      if (free_depth[sel] > 0) begin
        free_depth[sel]--;
        idx = int'(free_ids[sel][free_depth[sel]]) - base;
        if (idx < 0 || idx >= POOL_SLOTS) idx = 0;
      end else if (fresh_mark[sel] < POOL_SLOTS) begin
        idx = fresh_mark[sel];
        fresh_mark[sel]++;
      end else begin
        r.rid    = '0;
        r.status = ST_FULL;
        return r;
      end
      slot_count[sel][idx] = 16'd1;
      r.rid = ID_W'(idx + base);
      return r;
    end
    // path id zero stands for no path
    if (sel && sid == '0) return r;
    idx = int'(sid) - base;
    if (idx >= POOL_SLOTS || idx >= fresh_mark[sel] || slot_count[sel][idx] == '0) begin
      r.status = ST_BAD;
      return r;
    end
    r.unbound = (slot_count[sel][idx] == 16'd1);
    if (cmd == CMD_INC) begin
      if (slot_count[sel][idx] >= COUNT_MAX) r.status = ST_SAT;
      else slot_count[sel][idx]++;
    end else if (cmd == CMD_DEC) begin
      slot_count[sel][idx]--;
      if (slot_count[sel][idx] == '0) begin
        r.freed = 1'b1;
        if (free_depth[sel] < POOL_SLOTS) begin
          free_ids[sel][free_depth[sel]] = ID_W'(idx + base);
          free_depth[sel]++;
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [ID_W-1:0] want,
                             input logic [ID_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      for (int p = 0; p < 2; p++) begin
        for (int i = 0; i < POOL_SLOTS; i++) slot_count[p][i] = '0;
        free_depth[p] = 0;
        fresh_mark[p] = 0;
      end
      expected_answers.delete();
    end else begin
      if (done_i) begin
        if (expected_answers.size() == 0) begin
          error_count++;
          $display("%0t: result with no request pending, expected none, got id %0d status %0d",
                   $time, result_id_i, status_i);
        end else begin
          want = expected_answers.pop_front();
          check_field("result_id", want.rid, result_id_i);
          check_field("unbound", ID_W'(want.unbound), ID_W'(unbound_i));
          check_field("freed", ID_W'(want.freed), ID_W'(freed_i));
          check_field("status", ID_W'(want.status), ID_W'(status_i));
        end
      end
      if (start_i && !busy_i)
        expected_answers.insert(expected_answers.size(),
                                apply_request(command_i, pool_i, slot_id_i));
    end
  end

  initial error_count = 0;

endmodule

@@ tb/testbench.sv @@
// top of the slot allocator testbench: clock, reset, request stimulus and verdict
// depends on rsa_pkg, refcount_slot_allocator and slot_allocator_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rsa_pkg::*;

  localparam int POOL_VAR  = 0;
  localparam int POOL_PATH = 1;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  cmd_e            command;
  logic            pool;
  logic [ID_W-1:0] slot_id;
  logic            done;
  logic [ID_W-1:0] result_id;
  logic            unbound;
  logic            freed;
  status_e         status;
  int              errors;
  int              pending;
  int              allocs_issued [2];

  refcount_slot_allocator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .command_i   (command),
    .pool_i      (pool),
    .slot_id_i   (slot_id),
    .done_o      (done),
    .result_id_o (result_id),
    .unbound_o   (unbound),
    .freed_o     (freed),
    .status_o    (status)
  );

  slot_allocator_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .command_i   (command),
    .pool_i      (pool),
    .slot_id_i   (slot_id),
    .done_i      (done),
    .result_id_i (result_id),
    .unbound_i   (unbound),
    .freed_i     (freed),
    .status_i    (status),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // one request; returns just after the edge that accepted it with start still high
  task automatic issue(input cmd_e cmd, input int sel, input int id);
    logic hit;
    start   <= 1'b1;
    command <= cmd;
    pool    <= sel[0];
    slot_id <= id[ID_W-1:0];
    if (cmd == CMD_ALLOC) allocs_issued[sel]++;
    do begin
      @(negedge clk_i);
      hit = !busy;
      @(posedge clk_i);
    end while (!hit);
  endtask

  task automatic drain;
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  function automatic int pick_id(int sel);
    int span;
    if ($urandom_range(0, 99) < 25) return $urandom_range(0, 511);
    span = (allocs_issued[sel] + 1 > 256) ? 256 : allocs_issued[sel] + 1;
    return sel + $urandom_range(0, span);
  endfunction

  function automatic cmd_e pick_cmd;
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return CMD_ALLOC;
    if (r < 55) return CMD_INC;
    if (r < 85) return CMD_DEC;
    return CMD_QUERY;
  endfunction

  initial begin
    int burst;
    int gap;
    int sel;
    start            <= 1'b0;
    command          <= CMD_ALLOC;
    pool             <= 1'b0;
    slot_id          <= '0;
    allocs_issued[0] = 0;
    allocs_issued[1] = 0;
    rst_ni           <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: fresh ids, lifo reuse, path id zero, bad ids
    issue(CMD_ALLOC, POOL_VAR, 0);
    issue(CMD_ALLOC, POOL_VAR, 511);
    issue(CMD_ALLOC, POOL_PATH, 0);
    issue(CMD_ALLOC, POOL_PATH, 256);
    issue(CMD_QUERY, POOL_VAR, 0);
    issue(CMD_INC, POOL_VAR, 0);
    issue(CMD_QUERY, POOL_VAR, 0);
    issue(CMD_DEC, POOL_VAR, 0);
    issue(CMD_DEC, POOL_VAR, 0);
    issue(CMD_DEC, POOL_VAR, 0);
    issue(CMD_QUERY, POOL_VAR, 0);
    issue(CMD_ALLOC, POOL_VAR, 0);
    issue(CMD_INC, POOL_PATH, 0);
    issue(CMD_DEC, POOL_PATH, 0);
    issue(CMD_QUERY, POOL_PATH, 0);
    issue(CMD_DEC, POOL_PATH, 1);
    issue(CMD_ALLOC, POOL_PATH, 0);
    issue(CMD_QUERY, POOL_PATH, 1);
    issue(CMD_INC, POOL_VAR, 2);
    issue(CMD_DEC, POOL_VAR, 511);
    issue(CMD_QUERY, POOL_VAR, 256);
    issue(CMD_INC, POOL_PATH, 257);
    issue(CMD_QUERY, POOL_PATH, 256);
    issue(CMD_QUERY, POOL_PATH, 2);

    // count increments on variable slot 1, back to back
    issue(CMD_INC, POOL_VAR, 1);
    issue(CMD_INC, POOL_VAR, 1);
    issue(CMD_QUERY, POOL_VAR, 1);
    issue(CMD_DEC, POOL_VAR, 1);

    // hold off until every answer is back, then fill the path pool
    drain();
    for (int i = 0; i < 258; i++) issue(CMD_ALLOC, POOL_PATH, 0);
    issue(CMD_DEC, POOL_PATH, 256);
    issue(CMD_DEC, POOL_PATH, 5);
    issue(CMD_DEC, POOL_PATH, 100);
    for (int i = 0; i < 4; i++) issue(CMD_ALLOC, POOL_PATH, 0);

    // random requests in bursts
    burst = 0;
    for (int n = 0; n < 1300; n++) begin
      sel = $urandom_range(0, 1);
      issue(pick_cmd(), sel, pick_id(sel));
      if (n == 650) drain();
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end else begin
        burst--;
      end
    end

    drain();
    repeat (6) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
